/* hdl/brcs_pkg.sv */
package brcs_pkg;

    // internal arithmetic is 18-bit signed
    typedef logic signed [17:0] sum_t;
    typedef logic [11:0]        dim_t;

    typedef enum logic [1:0] {
        CFG_SRC_W = 2'd0,
        CFG_SRC_H = 2'd1,
        CFG_DST_W = 2'd2,
        CFG_DST_H = 2'd3
    } cfg_idx_t;

    function automatic sum_t ext_s16(logic [15:0] v);
        return sum_t'({{2{v[15]}}, v});
    endfunction

    function automatic sum_t ext_u12(logic [11:0] v);
        return sum_t'({6'd0, v});
    endfunction

endpackage

/* hdl/blit_region_clip_setup_top.sv */
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    region, target, transform, same-image, clip
// m_        out        m_valid / m_ready    nothing-to-do, temp flag, clamped region, copy box
// cfg_      in         cfg_wr_en            cfg_index, cfg_data (12-bit buffer sizes)
//
// Four register stages; one item per cycle while m_ready does not hold a full pipeline;
// a result passes stages 1 to 4 in order, and m_valid is the stage 4 valid bit.
// Stage 1 clamps clip and fixes negative source edges, stage 2 cuts the source at its
// bounds, stage 3 applies the transform and the left/top clip, stage 4 the right/bottom
// clip and drives the output register.
// Synchronous active-low reset clears the valid bits and the size registers.
// A stage advances when it is empty or the stage after it advances; bubbles close up
// under a stall, so s_ready can stay high while a result waits on m_ready.
module blit_region_clip_setup_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_region_x,
    input  logic [15:0] s_region_y,
    input  logic [15:0] s_region_width,
    input  logic [15:0] s_region_height,
    input  logic [15:0] s_target_x,
    input  logic [15:0] s_target_y,
    input  logic [2:0]  s_transform_code,
    input  logic        s_same_image,
    input  logic [15:0] s_clip_left,
    input  logic [15:0] s_clip_top,
    input  logic [15:0] s_clip_right,
    input  logic [15:0] s_clip_bottom,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_nothing_to_do,
    output logic        m_use_temp_copy,
    output logic [11:0] m_clamped_x,
    output logic [11:0] m_clamped_y,
    output logic [11:0] m_clamped_w,
    output logic [11:0] m_clamped_h,
    output logic [11:0] m_copy_src_x,
    output logic [11:0] m_copy_src_y,
    output logic [11:0] m_copy_dst_x,
    output logic [11:0] m_copy_dst_y,
    output logic [11:0] m_copy_w,
    output logic [11:0] m_copy_h
);

    localparam int DimLimInt = (MAX_DIM - 1 > 4095) ? 4095 : MAX_DIM - 1;
    localparam logic [11:0] DIM_LIM = 12'(DimLimInt);

    // ---------------- size registers ----------------
    brcs_pkg::dim_t src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    brcs_pkg::dim_t cfg_sat;

    assign cfg_sat = (cfg_data > DIM_LIM) ? DIM_LIM : cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= '0;
            src_h_reg <= '0;
            dst_w_reg <= '0;
            dst_h_reg <= '0;
        end else if (cfg_wr_en) begin
            case (brcs_pkg::cfg_idx_t'(cfg_index))
                brcs_pkg::CFG_SRC_W: src_w_reg <= cfg_sat;
                brcs_pkg::CFG_SRC_H: src_h_reg <= cfg_sat;
                brcs_pkg::CFG_DST_W: dst_w_reg <= cfg_sat;
                brcs_pkg::CFG_DST_H: dst_h_reg <= cfg_sat;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || m_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: clip clamp, negative source edges ----------------
    brcs_pkg::sum_t cl1_next, ct1_next, cr1_next, cb1_next;
    brcs_pkg::sum_t rx1_next, ry1_next, rw1_next, rh1_next;
    logic           empty1_next;
    brcs_pkg::sum_t cl_in, ct_in, cr_in, cb_in, rx_in, ry_in, rw_in, rh_in, dw_s, dh_s;

    always_comb begin
        cl_in = brcs_pkg::ext_s16(s_clip_left);
        ct_in = brcs_pkg::ext_s16(s_clip_top);
        cr_in = brcs_pkg::ext_s16(s_clip_right);
        cb_in = brcs_pkg::ext_s16(s_clip_bottom);
        rx_in = brcs_pkg::ext_s16(s_region_x);
        ry_in = brcs_pkg::ext_s16(s_region_y);
        rw_in = brcs_pkg::ext_s16(s_region_width);
        rh_in = brcs_pkg::ext_s16(s_region_height);
        dw_s  = brcs_pkg::ext_u12(dst_w_reg);
        dh_s  = brcs_pkg::ext_u12(dst_h_reg);

        cl1_next = cl_in[17] ? '0 : cl_in;
        ct1_next = ct_in[17] ? '0 : ct_in;
        cr1_next = (cr_in > dw_s) ? dw_s : cr_in;
        cb1_next = (cb_in > dh_s) ? dh_s : cb_in;
        empty1_next = (cl1_next >= cr1_next) || (ct1_next >= cb1_next);

        if (rx_in[17]) begin
            rx1_next = '0;
            rw1_next = rw_in + rx_in;
        end else begin
            rx1_next = rx_in;
            rw1_next = rw_in;
        end
        if (ry_in[17]) begin
            ry1_next = '0;
            rh1_next = rh_in + ry_in;
        end else begin
            ry1_next = ry_in;
            rh1_next = rh_in;
        end
    end

    brcs_pkg::sum_t cl1_reg, ct1_reg, cr1_reg, cb1_reg;
    brcs_pkg::sum_t rx1_reg, ry1_reg, rw1_reg, rh1_reg, dx1_reg, dy1_reg;
    logic [2:0]     tc1_reg;
    logic           same1_reg, empty1_reg;

    always_ff @(posedge aclk) begin
        if (en1 && s_valid) begin
            cl1_reg    <= cl1_next;
            ct1_reg    <= ct1_next;
            cr1_reg    <= cr1_next;
            cb1_reg    <= cb1_next;
            rx1_reg    <= rx1_next;
            ry1_reg    <= ry1_next;
            rw1_reg    <= rw1_next;
            rh1_reg    <= rh1_next;
            dx1_reg    <= brcs_pkg::ext_s16(s_target_x);
            dy1_reg    <= brcs_pkg::ext_s16(s_target_y);
            tc1_reg    <= s_transform_code;
            same1_reg  <= s_same_image;
            empty1_reg <= empty1_next;
        end
    end

    // ---------------- stage 2: source bound cut, clip distances ----------------
    brcs_pkg::sum_t sw_s, sh_s, ovx, ovy;
    brcs_pkg::sum_t cw2_next, ch2_next;
    logic           empty2_next;

    always_comb begin
        sw_s = brcs_pkg::ext_u12(src_w_reg);
        sh_s = brcs_pkg::ext_u12(src_h_reg);
        ovx  = rx1_reg + rw1_reg - sw_s;
        ovy  = ry1_reg + rh1_reg - sh_s;
        cw2_next = (ovx > 0) ? sw_s - rx1_reg : rw1_reg;
        ch2_next = (ovy > 0) ? sh_s - ry1_reg : rh1_reg;
        empty2_next = empty1_reg || (cw2_next <= 0) || (ch2_next <= 0);
    end

    brcs_pkg::sum_t cx2_reg, cy2_reg, cw2_reg, ch2_reg;
    brcs_pkg::sum_t dl2_reg, dt2_reg, rcl2_reg, rct2_reg, rdx2_reg, rdy2_reg;
    brcs_pkg::sum_t cl2_reg, ct2_reg, dx2_reg, dy2_reg;
    logic [2:0]     tc2_reg;
    logic           same2_reg, empty2_reg;

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            cx2_reg    <= rx1_reg;
            cy2_reg    <= ry1_reg;
            cw2_reg    <= cw2_next;
            ch2_reg    <= ch2_next;
            dl2_reg    <= cl1_reg - dx1_reg;
            dt2_reg    <= ct1_reg - dy1_reg;
            rcl2_reg   <= cr1_reg - cl1_reg;
            rct2_reg   <= cb1_reg - ct1_reg;
            rdx2_reg   <= cr1_reg - dx1_reg;
            rdy2_reg   <= cb1_reg - dy1_reg;
            cl2_reg    <= cl1_reg;
            ct2_reg    <= ct1_reg;
            dx2_reg    <= dx1_reg;
            dy2_reg    <= dy1_reg;
            tc2_reg    <= tc1_reg;
            same2_reg  <= same1_reg;
            empty2_reg <= empty2_next;
        end
    end

    // ---------------- stage 3: transform, left/top clip ----------------
    logic           temp3_next, swap3;
    brcs_pkg::sum_t sxo_b, syo_b, w_b, h_b;
    brcs_pkg::sum_t sxo3_next, syo3_next, w3_next, h3_next;
    brcs_pkg::sum_t dx3_next, dy3_next, limw3_next, limh3_next;

    always_comb begin
        temp3_next = same2_reg || (tc2_reg != 3'd0);
        swap3      = tc2_reg[2];
        sxo_b = temp3_next ? '0 : cx2_reg;
        syo_b = temp3_next ? '0 : cy2_reg;
        w_b   = swap3 ? ch2_reg : cw2_reg;
        h_b   = swap3 ? cw2_reg : ch2_reg;

        // right limit is cr - dx, taken after dx moves to the clip edge
        if (dl2_reg > 0) begin
            sxo3_next  = sxo_b + dl2_reg;
            w3_next    = w_b - dl2_reg;
            dx3_next   = cl2_reg;
            limw3_next = rcl2_reg;
        end else begin
            sxo3_next  = sxo_b;
            w3_next    = w_b;
            dx3_next   = dx2_reg;
            limw3_next = rdx2_reg;
        end
        if (dt2_reg > 0) begin
            syo3_next  = syo_b + dt2_reg;
            h3_next    = h_b - dt2_reg;
            dy3_next   = ct2_reg;
            limh3_next = rct2_reg;
        end else begin
            syo3_next  = syo_b;
            h3_next    = h_b;
            dy3_next   = dy2_reg;
            limh3_next = rdy2_reg;
        end
    end

    brcs_pkg::sum_t cx3_reg, cy3_reg, cw3_reg, ch3_reg;
    brcs_pkg::sum_t sxo3_reg, syo3_reg, w3_reg, h3_reg;
    brcs_pkg::sum_t dx3_reg, dy3_reg, limw3_reg, limh3_reg;
    logic           temp3_reg, empty3_reg;

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            cx3_reg    <= cx2_reg;
            cy3_reg    <= cy2_reg;
            cw3_reg    <= cw2_reg;
            ch3_reg    <= ch2_reg;
            sxo3_reg   <= sxo3_next;
            syo3_reg   <= syo3_next;
            w3_reg     <= w3_next;
            h3_reg     <= h3_next;
            dx3_reg    <= dx3_next;
            dy3_reg    <= dy3_next;
            limw3_reg  <= limw3_next;
            limh3_reg  <= limh3_next;
            temp3_reg  <= temp3_next;
            empty3_reg <= empty2_reg;
        end
    end

    // ---------------- stage 4: right/bottom clip, output register ----------------
    brcs_pkg::sum_t wf, hf;
    logic           none4_next;

    always_comb begin
        wf = (w3_reg > limw3_reg) ? limw3_reg : w3_reg;
        hf = (h3_reg > limh3_reg) ? limh3_reg : h3_reg;
        none4_next = empty3_reg || (wf <= 0) || (hf <= 0);
    end

    logic        none4_reg, temp4_reg;
    logic [11:0] cx4_reg, cy4_reg, cw4_reg, ch4_reg;
    logic [11:0] sxo4_reg, syo4_reg, dx4_reg, dy4_reg, w4_reg, h4_reg;

    always_ff @(posedge aclk) begin
        if (en4 && v3_reg) begin
            none4_reg <= none4_next;
            if (none4_next) begin
                temp4_reg <= 1'b0;
                cx4_reg   <= '0;
                cy4_reg   <= '0;
                cw4_reg   <= '0;
                ch4_reg   <= '0;
                sxo4_reg  <= '0;
                syo4_reg  <= '0;
                dx4_reg   <= '0;
                dy4_reg   <= '0;
                w4_reg    <= '0;
                h4_reg    <= '0;
            end else begin
                temp4_reg <= temp3_reg;
                cx4_reg   <= cx3_reg[11:0];
                cy4_reg   <= cy3_reg[11:0];
                cw4_reg   <= cw3_reg[11:0];
                ch4_reg   <= ch3_reg[11:0];
                sxo4_reg  <= sxo3_reg[11:0];
                syo4_reg  <= syo3_reg[11:0];
                dx4_reg   <= dx3_reg[11:0];
                dy4_reg   <= dy3_reg[11:0];
                w4_reg    <= wf[11:0];
                h4_reg    <= hf[11:0];
            end
        end
    end

    assign m_valid         = v4_reg;
    assign m_nothing_to_do = none4_reg;
    assign m_use_temp_copy = temp4_reg;
    assign m_clamped_x     = cx4_reg;
    assign m_clamped_y     = cy4_reg;
    assign m_clamped_w     = cw4_reg;
    assign m_clamped_h     = ch4_reg;
    assign m_copy_src_x    = sxo4_reg;
    assign m_copy_src_y    = syo4_reg;
    assign m_copy_dst_x    = dx4_reg;
    assign m_copy_dst_y    = dy4_reg;
    assign m_copy_w        = w4_reg;
    assign m_copy_h        = h4_reg;

endmodule
